### src/tti_pkg.sv
// shared constants, types and calibration rom contents for the thermistor interpolator
package tti_pkg;

  // field widths
  localparam int unsigned ADC_W    = 16;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned TEMP_W   = 13;
  localparam int unsigned STATUS_W = 2;

  // widest point index any table size can use (up to 64 entries)
  localparam int unsigned PT_IDX_W = 6;

  // calibration rom
  localparam int unsigned ROM_POINTS = 26;
  localparam int unsigned ROM_IDX_W  = 5;

  // temperature before saturation, quotient and dividend widths
  localparam int unsigned SUM_W  = 15;
  localparam int unsigned QUO_W  = CFG_W + 1;
  localparam int unsigned PROD_W = ADC_W + CFG_W;
  localparam int unsigned DVD_W  = PROD_W + 1;

  localparam logic [TEMP_W-1:0] TEMP_MAX = '1;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_START = 1'b0,
    CFG_STEP  = 1'b1
  } cfg_idx_e;

  // range status codes
  typedef enum logic [STATUS_W-1:0] {
    RS_INSIDE   = 2'd0,
    RS_LOW      = 2'd1,
    RS_HIGH     = 2'd2,
    RS_RESERVED = 2'd3
  } range_status_e;

  typedef logic [ADC_W-1:0] point_t;

  localparam point_t CAL_ROM [ROM_POINTS] = '{
    16'd1703, 16'd1916, 16'd2115, 16'd2302, 16'd2478, 16'd2643, 16'd2799,
    16'd2947, 16'd3087, 16'd3219, 16'd3345, 16'd3465, 16'd3578, 16'd3687,
    16'd3790, 16'd3889, 16'd3984, 16'd4074, 16'd4160, 16'd4243, 16'd4323,
    16'd4400, 16'd4473, 16'd4544, 16'd4612, 16'd4678
  };

  // points past the end of the rom repeat the last one
  function automatic point_t point_at(input logic [PT_IDX_W-1:0] idx);
    point_t p;
    if (idx >= PT_IDX_W'(ROM_POINTS)) begin
      p = CAL_ROM[ROM_POINTS-1];
    end else begin
      p = CAL_ROM[idx[ROM_IDX_W-1:0]];
    end
    return p;
  endfunction

endpackage

### src/thermistor_table_interpolator_unit.sv
// thermistor reading to temperature converter: rom binary search and interpolation
//
// Each accepted adc_sum beat is turned into one temperature beat. The calibration
// points sit in a synchronous rom with a registered read; the sequencer reads the
// last point, then the first, then one point per binary-search probe until the
// bracket is found. The fraction between two points is formed by one 8x16 multiply
// and a nine-step restoring division, one quotient bit per cycle. A reading clamped
// high or low skips the search and the division. in_ready_o rises the cycle after
// the result is loaded; a result that still waits in the output register when the
// next one is done holds the sequencer until it is taken.
// One item is worked on at a time; a new beat is taken as soon as the previous result
// sits in the output register, even while that result still waits to be taken.
// range_status reports 0 inside the table, 1 clamped low, 2 clamped high.
module thermistor_table_interpolator_unit #(
  parameter int unsigned TABLE_ENTRIES = 26
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [tti_pkg::CFG_W-1:0]     cfg_data_i,
  // reading in
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tti_pkg::ADC_W-1:0]     adc_sum_i,
  // temperature out
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tti_pkg::TEMP_W-1:0]    temperature_o,
  output logic [tti_pkg::STATUS_W-1:0]  range_status_o
);
  import tti_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] MID0_IDX = IDX_W'((TABLE_ENTRIES - 1) / 2);
  localparam int unsigned CNT_W = $clog2(QUO_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK_HI,
    S_CHK_LO,
    S_SEARCH,
    S_PREP,
    S_ROUND,
    S_DIV,
    S_FIN
  } state_e;

  state_e                state_q;
  logic [CFG_W-1:0]      table_start_q, table_step_q;
  logic [ADC_W-1:0]      adc_q;
  logic [IDX_W-1:0]      lo_q, hi_q, mid_q;
  point_t                vlo_q, vhi_q;
  logic                  clamp_q, nodiv_q;
  logic [STATUS_W-1:0]   status_q;
  logic [SUM_W-1:0]      base_q;
  logic [PROD_W-1:0]     prod_q;
  logic [ADC_W-1:0]      gap_q, rem_q;
  logic [QUO_W-1:0]      dsh_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  out_valid_q;
  logic [TEMP_W-1:0]     temp_q;
  logic [STATUS_W-1:0]   rs_q;

  // rom read port
  logic [IDX_W-1:0]      rd_addr;
  point_t                rom_q;

  // search step
  logic [IDX_W-1:0]      lo_n, hi_n, mid_n;
  logic [IDX_W:0]        mid_sum;
  point_t                vlo_n, vhi_n;

  // datapath helpers
  logic                  exact;
  logic [DVD_W-1:0]      dividend;
  logic [ADC_W:0]        trial;
  logic                  qbit;
  logic [SUM_W-1:0]      temp_sum;
  logic                  out_free;
  logic                  out_load;

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign temperature_o  = temp_q;
  assign range_status_o = rs_q;
  assign out_free       = !out_valid_q || out_ready_i;
  assign out_load       = (state_q == S_FIN) && out_free;

  // one probe: narrow the bracket around the reading
  always_comb begin
    lo_n  = lo_q;
    hi_n  = hi_q;
    vlo_n = vlo_q;
    vhi_n = vhi_q;
    if (adc_q > rom_q) begin
      lo_n  = mid_q;
      vlo_n = rom_q;
    end else begin
      hi_n  = mid_q;
      vhi_n = rom_q;
    end
    mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
    mid_n   = mid_sum[IDX_W:1];
  end

  // address for the next rom read
  always_comb begin
    unique case (state_q)
      S_IDLE:   rd_addr = LAST_IDX;
      S_CHK_HI: rd_addr = '0;
      S_CHK_LO: rd_addr = MID0_IDX;
      S_SEARCH: rd_addr = mid_n;
      default:  rd_addr = mid_q;
    endcase
  end

  // calibration rom, registered read
  always_ff @(posedge clk_i) begin
    rom_q <= point_at(PT_IDX_W'(rd_addr));
  end

  // division step and final sum
  always_comb begin
    exact    = clamp_q || (adc_q >= vhi_q);
    dividend = {1'b0, prod_q} + DVD_W'(gap_q >> 1);
    trial    = {rem_q, dsh_q[QUO_W-1]};
    qbit     = (trial >= {1'b0, gap_q});
    temp_sum = base_q + (nodiv_q ? '0 : SUM_W'(dsh_q));
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_start_q <= '0;
      table_step_q  <= CFG_W'(20);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START: table_start_q <= cfg_data_i;
        CFG_STEP:  table_step_q  <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      temp_q      <= '0;
      rs_q        <= RS_INSIDE;
      adc_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      vlo_q       <= '0;
      vhi_q       <= '0;
      clamp_q     <= 1'b0;
      nodiv_q     <= 1'b0;
      status_q    <= RS_INSIDE;
      base_q      <= '0;
      prod_q      <= '0;
      gap_q       <= '0;
      rem_q       <= '0;
      dsh_q       <= '0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            adc_q    <= adc_sum_i;
            lo_q     <= '0;
            hi_q     <= LAST_IDX;
            clamp_q  <= 1'b0;
            status_q <= RS_INSIDE;
            state_q  <= S_CHK_HI;
          end
        end
        // rom holds the last point
        S_CHK_HI: begin
          vhi_q <= rom_q;
          if (adc_q >= rom_q) begin
            clamp_q  <= 1'b1;
            status_q <= RS_HIGH;
            state_q  <= S_PREP;
          end else begin
            state_q <= S_CHK_LO;
          end
        end
        // rom holds the first point
        S_CHK_LO: begin
          vlo_q <= rom_q;
          mid_q <= MID0_IDX;
          if (adc_q <= rom_q) begin
            clamp_q  <= 1'b1;
            hi_q     <= '0;
            status_q <= RS_LOW;
            state_q  <= S_PREP;
          end else if (LAST_IDX > IDX_W'(1)) begin
            state_q <= S_SEARCH;
          end else begin
            state_q <= S_PREP;
          end
        end
        // rom holds the point at mid
        S_SEARCH: begin
          lo_q  <= lo_n;
          hi_q  <= hi_n;
          vlo_q <= vlo_n;
          vhi_q <= vhi_n;
          mid_q <= mid_n;
          if ((hi_n - lo_n) <= IDX_W'(1)) begin
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          base_q  <= SUM_W'(table_start_q)
                   + SUM_W'(table_step_q) * SUM_W'(exact ? hi_q : lo_q);
          prod_q  <= PROD_W'(table_step_q) * PROD_W'(adc_q - vlo_q);
          gap_q   <= vhi_q - vlo_q;
          nodiv_q <= exact || (vhi_q == vlo_q);
          dsh_q   <= '0;
          state_q <= (exact || (vhi_q == vlo_q)) ? S_FIN : S_ROUND;
        end
        // add half the gap, load the divider
        S_ROUND: begin
          rem_q   <= dividend[DVD_W-1:QUO_W];
          dsh_q   <= dividend[QUO_W-1:0];
          cnt_q   <= CNT_W'(QUO_W - 1);
          state_q <= S_DIV;
        end
        // restoring division, one quotient bit per cycle
        S_DIV: begin
          rem_q <= qbit ? ADC_W'(trial - {1'b0, gap_q}) : trial[ADC_W-1:0];
          dsh_q <= {dsh_q[QUO_W-2:0], qbit};
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            temp_q      <= (temp_sum > SUM_W'(TEMP_MAX)) ? TEMP_MAX : temp_sum[TEMP_W-1:0];
            rs_q        <= status_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // bracket stays around the reading while probing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> (vlo_q < adc_q) && (adc_q <= vhi_q) && (lo_q < hi_q))
    else $error("search bracket lost the reading");

  // partial remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < gap_q)
    else $error("divider remainder out of range");

  // low clamp gives the start temperature
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (range_status_o == RS_LOW) |-> temperature_o == TEMP_W'(table_start_q))
    else $error("low clamp temperature wrong");

  // reserved status code never leaves the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> range_status_o != RS_RESERVED)
    else $error("reserved range status on output");

endmodule

### dv/tb_thermistor_table_interpolator_unit.sv
// testbench for the thermistor table interpolator: directed and random readings against a predictor
`timescale 1ns / 1ps

module tb_thermistor_table_interpolator_unit;
  import tti_pkg::*;

  localparam int unsigned N_POINTS    = 26;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 30;

  // own copy of the calibration curve
  localparam logic [15:0] CURVE [26] = '{
    16'd1703, 16'd1916, 16'd2115, 16'd2302, 16'd2478, 16'd2643, 16'd2799,
    16'd2947, 16'd3087, 16'd3219, 16'd3345, 16'd3465, 16'd3578, 16'd3687,
    16'd3790, 16'd3889, 16'd3984, 16'd4074, 16'd4160, 16'd4243, 16'd4323,
    16'd4400, 16'd4473, 16'd4544, 16'd4612, 16'd4678
  };

  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    range_status_e     status;
  } temp_beat_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic                cfg_idx_i      = 1'b0;
  logic [CFG_W-1:0]    cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [ADC_W-1:0]    adc_sum_i      = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [TEMP_W-1:0]   temperature_o;
  logic [STATUS_W-1:0] range_status_o;

  // shadow of the table registers
  logic [CFG_W-1:0] start_shadow = 8'd0;
  logic [CFG_W-1:0] step_shadow  = 8'd20;

  temp_beat_t  pending_temps[$];
  int unsigned failures     = 0;
  int unsigned cycle_count  = 0;
  int unsigned stall_left   = 0;
  bit          quiet_mode   = 1'b0;

  thermistor_table_interpolator_unit #(
    .TABLE_ENTRIES(N_POINTS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .adc_sum_i     (adc_sum_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .temperature_o (temperature_o),
    .range_status_o(range_status_o)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // curve point, repeating the last one past the end
  function automatic int unsigned curve_point(input int unsigned idx);
    if (idx >= 26) begin
      return CURVE[25];
    end
    return CURVE[idx];
  endfunction

  // expected temperature and range status for one reading
  function automatic temp_beat_t predict_temperature(input logic [ADC_W-1:0] reading);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned v_lo;
    int unsigned v_hi;
    int unsigned gap;
    int unsigned t;
    temp_beat_t  r;
    lo = 0;
    hi = N_POINTS - 1;
    if (reading >= curve_point(hi)) begin
      t = start_shadow + step_shadow * hi;
      r.status = RS_HIGH;
    end else if (reading <= curve_point(0)) begin
      t = start_shadow;
      r.status = RS_LOW;
    end else begin
      // bracket keeps point(lo) < reading <= point(hi)
      while (hi - lo > 1) begin
        mid = (lo + hi) >> 1;
        if (reading > curve_point(mid)) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
      v_lo = curve_point(lo);
      v_hi = curve_point(hi);
      if (reading >= v_hi) begin
        t = start_shadow + step_shadow * hi;
      end else begin
        t = start_shadow + step_shadow * lo;
        gap = v_hi - v_lo;
        if (gap != 0) begin
          t = t + (step_shadow * (reading - v_lo) + (gap >> 1)) / gap;
        end
      end
      r.status = RS_INSIDE;
    end
    r.temperature = (t > 8191) ? '1 : t[TEMP_W-1:0];
    return r;
  endfunction

  // send one reading beat, with an optional idle burst ahead of it
  task automatic send_reading(input logic [ADC_W-1:0] reading);
    int unsigned gap;
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      adc_sum_i  <= ADC_W'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    adc_sum_i  <= reading;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    pending_temps.push_back(predict_temperature(reading));
  endtask

  // lower valid and wait until every result has come back
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_temps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // write both table registers back to back, block idle
  task automatic set_table(input logic [CFG_W-1:0] start_val, input logic [CFG_W-1:0] step_val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_START;
    cfg_data_i <= start_val;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_STEP;
    cfg_data_i <= step_val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_data_i <= '0;
    start_shadow = start_val;
    step_shadow  = step_val;
    @(posedge clk_i);
  endtask

  // mostly readings inside the table, some on or next to points, some anywhere
  function automatic logic [ADC_W-1:0] random_reading;
    int unsigned sel;
    int unsigned p;
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      return ADC_W'($urandom_range(1704, 4677));
    end else if (sel < 82) begin
      p = curve_point($urandom_range(0, 25));
      return ADC_W'(p + $urandom_range(0, 2) - 1);
    end
    return ADC_W'($urandom);
  endfunction

  task automatic random_readings(input int unsigned count);
    repeat (count) send_reading(random_reading());
    drain();
  endtask

  // register reset values, clamps, exact points and a rounding half
  task automatic test_reset_values;
    logic [ADC_W-1:0] readings [18];
    readings = '{16'd0, 16'd65535, 16'd1702, 16'd1703, 16'd1704, 16'd1916,
                 16'd1915, 16'd1917, 16'd2324, 16'd3000, 16'd3578, 16'd4677,
                 16'd4678, 16'd4679, 16'h5555, 16'hAAAA, 16'd2010, 16'd4612};
    foreach (readings[i]) send_reading(readings[i]);
    drain();
  endtask

  // corners of start and step
  task automatic test_extreme_settings;
    set_table(8'd0, 8'd0);
    random_readings(60);
    set_table(8'd255, 8'd255);
    random_readings(60);
    set_table(8'd0, 8'd255);
    random_readings(60);
    set_table(8'd255, 8'd0);
    random_readings(60);
  endtask

  task automatic test_random_settings;
    repeat (3) begin
      set_table(CFG_W'($urandom), CFG_W'($urandom));
      random_readings(60);
    end
  endtask

  // no idling on either side
  task automatic test_back_to_back;
    set_table(CFG_W'($urandom), CFG_W'($urandom));
    quiet_mode = 1'b1;
    random_readings(130);
  endtask

  // result side stalls in bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      stall_left  <= $urandom_range(1, 15) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result checker, sampled away from the driving edge
  always @(negedge clk_i) begin
    temp_beat_t exp_beat;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_temps.size() == 0) begin
        $error("result beat with none expected: temperature %0d range_status %0d",
               temperature_o, range_status_o);
        failures++;
      end else begin
        exp_beat = pending_temps.pop_front();
        if (temperature_o !== exp_beat.temperature) begin
          $error("temperature: expected %0d, actual %0d", exp_beat.temperature, temperature_o);
          failures++;
        end
        if (range_status_o !== exp_beat.status) begin
          $error("range_status: expected %0d, actual %0d", exp_beat.status, range_status_o);
          failures++;
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_extreme_settings();
    test_random_settings();
    test_back_to_back();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (failures == 0 && pending_temps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### thermistor_table_interpolator_unit.f
src/tti_pkg.sv
src/thermistor_table_interpolator_unit.sv
dv/tb_thermistor_table_interpolator_unit.sv
